@@ hw/rtl/sasmd_pkg.sv @@
`default_nettype none
package sasmd_pkg;

   localparam int WIDTH   = 32;
   localparam int FIELD_W = 32;
   localparam int CNT_W   = $clog2(WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } ctl_type;

endpackage
`default_nettype wire

@@ hw/rtl/sasmd_req_if.sv @@
`default_nettype none
interface sasmd_req_if
   import sasmd_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] operand_a;
   logic [FIELD_W-1:0] operand_b;

   modport source (output valid, output operand_a, output operand_b, input ready);
   modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/sasmd_rsp_if.sv @@
`default_nettype none
interface sasmd_rsp_if
   import sasmd_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] sum_out;
   logic [FIELD_W-1:0] difference_out;
   logic [FIELD_W-1:0] product_low;
   logic [FIELD_W-1:0] quotient_out;
   logic               divide_by_zero;

   modport source (output valid, output sum_out, output difference_out,
                   output product_low, output quotient_out, output divide_by_zero,
                   input ready);
   modport sink   (input valid, input sum_out, input difference_out,
                   input product_low, input quotient_out, input divide_by_zero,
                   output ready);
endinterface
`default_nettype wire

@@ hw/rtl/shift_add_sub_mul_div_alu.sv @@
// A req transfer starts the WIDTH-step multiply/divide loop (one step per operand bit);
// rsp valid rises when the loop ends and holds until the rsp transfer.
// The block takes no new req until the rsp for the last one has transferred.
// req_ready is low from a req transfer until the rsp transfer completes.
// Reset: synchronous, active high; returns the sequencer to idle, no rsp pending.
`default_nettype none
module shift_add_sub_mul_div_alu
   import sasmd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   sasmd_req_if.sink  req,
   sasmd_rsp_if.source rsp
);

   ctl_type ctl;

   sasmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .ctl       (ctl)
   );

   sasmd_step u_step (
      .clock          (clock),
      .ctl            (ctl),
      .operand_a      (req.operand_a),
      .operand_b      (req.operand_b),
      .sum_out        (rsp.sum_out),
      .difference_out (rsp.difference_out),
      .product_low    (rsp.product_low),
      .quotient_out   (rsp.quotient_out),
      .divide_by_zero (rsp.divide_by_zero)
   );

`ifndef SYNTHESIS
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid))
      else $error("req_ready and rsp_valid both high");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (!req.ready && !rsp.valid))
      else $error("not busy after req transfer");

   a_dz: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.divide_by_zero) |-> (rsp.quotient_out == '0))
      else $error("nonzero quotient on divide by zero");

   a_rst: assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("rsp_valid after reset");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/sasmd_ctrl.sv @@
`default_nettype none
module sasmd_ctrl
   import sasmd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output ctl_type      ctl
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(WIDTH - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign ctl.load  = req_ready && req_valid;
   assign ctl.step  = (state_ff == ST_RUN);

endmodule
`default_nettype wire

@@ hw/rtl/sasmd_step.sv @@
`default_nettype none
module sasmd_step
   import sasmd_pkg::*;
(
   input  wire logic               clock,
   input  wire ctl_type            ctl,
   input  wire logic [FIELD_W-1:0] operand_a,
   input  wire logic [FIELD_W-1:0] operand_b,
   output logic [FIELD_W-1:0]      sum_out,
   output logic [FIELD_W-1:0]      difference_out,
   output logic [FIELD_W-1:0]      product_low,
   output logic [FIELD_W-1:0]      quotient_out,
   output logic                    divide_by_zero
);

   logic [WIDTH-1:0] mcand_ff, mcand_in;
   logic [WIDTH-1:0] mplier_ff, mplier_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvd_ff, dvd_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [WIDTH-1:0] sum_ff, sum_in;
   logic [WIDTH-1:0] diff_ff, diff_in;
   logic             dz_ff, dz_in;

   logic [WIDTH-1:0] a_w, b_w;
   logic [WIDTH:0]   rem_sh;
   logic [WIDTH+1:0] trial;
   logic             qbit;

   assign a_w    = WIDTH'(operand_a);
   assign b_w    = WIDTH'(operand_b);
   assign rem_sh = {rem_ff, dvd_ff[WIDTH-1]};
   assign trial  = {1'b0, rem_sh} - {2'b00, dvs_ff};
   assign qbit   = ~trial[WIDTH+1];

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      sum_in    = sum_ff;
      diff_in   = diff_ff;
      dz_in     = dz_ff;
      if (ctl.load) begin
         mcand_in  = a_w;
         mplier_in = b_w;
         acc_in    = '0;
         rem_in    = '0;
         dvd_in    = a_w;
         dvs_in    = b_w;
         sum_in    = a_w + b_w;
         diff_in   = a_w - b_w;
         dz_in     = (b_w == '0);
      end else if (ctl.step) begin
         // shift-add multiply step
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[WIDTH-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[WIDTH-1:1]};
         // restoring divide step, quotient shifts in at the dividend LSB
         rem_in = qbit ? trial[WIDTH-1:0] : rem_sh[WIDTH-1:0];
         dvd_in = {dvd_ff[WIDTH-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      dvd_ff    <= dvd_in;
      dvs_ff    <= dvs_in;
      sum_ff    <= sum_in;
      diff_ff   <= diff_in;
      dz_ff     <= dz_in;
   end

   assign sum_out        = FIELD_W'(sum_ff);
   assign difference_out = FIELD_W'(diff_ff);
   assign product_low    = FIELD_W'(acc_ff);
   assign quotient_out   = dz_ff ? '0 : FIELD_W'(dvd_ff);
   assign divide_by_zero = dz_ff;

endmodule
`default_nettype wire

@@ tb/sv/shift_add_sub_mul_div_alu_tb.sv @@
`default_nettype none
module shift_add_sub_mul_div_alu_tb
   import sasmd_pkg::*;
   ;

   localparam int RANDOM_ITEMS = 1440;
   localparam int PHASES       = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int LIMIT_CYCLES = 1_000_000;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [FIELD_W-1:0] sum_out;
      logic [FIELD_W-1:0] difference_out;
      logic [FIELD_W-1:0] product_low;
      logic [FIELD_W-1:0] quotient_out;
      logic               divide_by_zero;
   } alu_result_type;

   class alu_scoreboard;
      alu_result_type pending_results[$];
      int unsigned    mismatches;

      function new();
         mismatches = 0;
      endfunction

      function void note_operands(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
         alu_result_type r;
         r.sum_out        = a + b;
         r.difference_out = a - b;
         r.product_low    = a * b;
         r.divide_by_zero = (b == '0);
         r.quotient_out   = r.divide_by_zero ? '0 : a / b;
         pending_results.push_back(r);
      endfunction

      function void flag_field(string field, logic [FIELD_W-1:0] want,
                               logic [FIELD_W-1:0] got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch on %s: expected %h, got %h", field, want, got);
         end
      endfunction

      function void check_result(alu_result_type got);
         alu_result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected rsp transfer: %h", got);
            end
            return;
         end
         want = pending_results.pop_front();
         if (got.sum_out !== want.sum_out)
            flag_field("sum_out", want.sum_out, got.sum_out);
         if (got.difference_out !== want.difference_out)
            flag_field("difference_out", want.difference_out, got.difference_out);
         if (got.product_low !== want.product_low)
            flag_field("product_low", want.product_low, got.product_low);
         if (got.quotient_out !== want.quotient_out)
            flag_field("quotient_out", want.quotient_out, got.quotient_out);
         if (got.divide_by_zero !== want.divide_by_zero)
            flag_field("divide_by_zero", FIELD_W'(want.divide_by_zero),
                       FIELD_W'(got.divide_by_zero));
      endfunction
   endclass

   logic clock;
   logic reset;

   sasmd_req_if req_ch ();
   sasmd_rsp_if rsp_ch ();

   shift_add_sub_mul_div_alu u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   alu_scoreboard sb;
   int unsigned   req_idle_pct;
   int unsigned   rsp_stall_pct;
   logic          long_hold_pending;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * LIMIT_CYCLES);
      $display("shift_add_sub_mul_div_alu_tb failed");
      $finish;
   end

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         IDLE_SENDER: begin
            req_idle_pct  = 46;
            rsp_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            req_idle_pct  = 0;
            rsp_stall_pct = 46;
         end
         default: begin
            req_idle_pct  = 7;
            rsp_stall_pct = 7;
         end
      endcase
   endtask

   // entered and left at a falling edge
   task automatic send_operands(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operand_a <= a;
      req_ch.operand_b <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_operands(a, b);
      @(negedge clock);
   endtask

   function automatic logic [FIELD_W-1:0] pick_operand();
      case ($urandom_range(0, 6))
         0: return FIELD_W'($urandom_range(0, 255));
         1: return FIELD_W'(1) << $urandom_range(0, FIELD_W - 1);
         2: return '1 - FIELD_W'($urandom_range(0, 15));
         3: return $urandom >> $urandom_range(0, FIELD_W - 1);
         default: return $urandom;
      endcase
   endfunction

   // response side: random stalls, plus one long hold-off on request
   initial begin
      logic hold_done;

      hold_done    = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_pending && !hold_done) begin
            hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_result('{rsp_ch.sum_out, rsp_ch.difference_out, rsp_ch.product_low,
                           rsp_ch.quotient_out, rsp_ch.divide_by_zero});
      end
   end

   initial begin
      logic [FIELD_W-1:0] a;
      logic [FIELD_W-1:0] b;
      int                 drain;

      sb                = new();
      long_hold_pending = 1'b0;
      req_idle_pct      = 0;
      rsp_stall_pct     = 0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.operand_a  = '0;
      req_ch.operand_b  = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // field extremes, divide by zero, wraparound
      send_operands('0, '0);
      send_operands('0, 32'd1);
      send_operands(32'd1, '0);
      send_operands('1, '0);
      send_operands('1, '1);
      send_operands('1, 32'd1);
      send_operands(32'd1, '1);
      send_operands('0, '1);
      send_operands(32'h8000_0000, 32'h8000_0000);
      send_operands(32'h8000_0000, 32'd2);
      send_operands(32'h7FFF_FFFF, 32'h8000_0000);
      send_operands(32'd7, 32'd7);
      send_operands(32'd6, 32'd7);
      send_operands(32'd100, 32'd3);
      send_operands('1, 32'h0001_0000);
      send_operands(32'hAAAA_AAAA, 32'h5555_5555);
      send_operands(32'h5555_5555, 32'hAAAA_AAAA);
      send_operands(32'h0001_0000, 32'h0001_0000);

      for (int phase = 0; phase < PHASES; phase++) begin
         set_idling(idle_mode_type'(phase % 4));
         if (phase == 2) long_hold_pending = 1'b1;
         for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
            a = pick_operand();
            b = ($urandom_range(0, 99) < 4) ? '0 : pick_operand();
            send_operands(a, b);
         end
      end
      req_ch.valid <= 1'b0;

      while (sb.pending_results.size() != 0) @(posedge clock);
      for (drain = 0; drain < DRAIN_CYCLES; drain++) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
         $display("shift_add_sub_mul_div_alu_tb passed");
      end else begin
         $display("shift_add_sub_mul_div_alu_tb failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ filelist.f @@
hw/rtl/sasmd_pkg.sv
hw/rtl/sasmd_req_if.sv
hw/rtl/sasmd_rsp_if.sv
hw/rtl/sasmd_ctrl.sv
hw/rtl/sasmd_step.sv
hw/rtl/shift_add_sub_mul_div_alu.sv
tb/sv/shift_add_sub_mul_div_alu_tb.sv
